### design/mmd_pkg.sv
// Shared definitions for the min/max decimator: field widths, parameter
// defaults, register indexes and the flush request handed to the sweep unit.
// No dependencies.
package mmd_pkg;

	localparam int MAX_CHANNELS_DEF = 64;
	localparam int SAMPLE_BITS_DEF  = 16;

	localparam int CHANNEL_W   = 6;
	localparam int PIXEL_W     = 16;
	localparam int COUNT_W     = 7;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST    = 7'd1;
	localparam logic [PIXEL_W-1:0] DECIMATION_RST       = 16'd1;
	localparam logic [PIXEL_W-1:0] PIXELS_PER_FRAME_RST = 16'd512;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CHANNEL_COUNT    = 2'd0,
		REG_DECIMATION       = 2'd1,
		REG_PIXELS_PER_FRAME = 2'd2
	} cfg_reg_t;

	// One flush of results: which pixel they carry and whether it is partial.
	typedef struct packed {
		logic               start;
		logic               partial;
		logic [PIXEL_W-1:0] pixel;
	} sweep_req_t;

endpackage

### design/mmd_mem.sv
// Min/max store: one write port, one read port, registered read data.
// Depends on nothing; widths come from the instantiating module.
module mmd_mem #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/mmd_sweep.sv
// Result sweep: walks channels 0..last through the store's read port and
// drives the result channel through an output register.
// Depends on mmd_pkg.
module mmd_sweep #(
	parameter int CH_W        = 6,
	parameter int SAMPLE_BITS = mmd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mmd_pkg::sweep_req_t          req,
	input  logic [CH_W-1:0]              req_last_ch,
	output logic                         busy,
	output logic                         rd_en,
	output logic [CH_W-1:0]              rd_addr,
	input  logic [2*SAMPLE_BITS-1:0]     rd_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mmd_pkg::CHANNEL_W-1:0] channel,
	output logic [mmd_pkg::PIXEL_W-1:0]  pixel,
	output logic [SAMPLE_BITS-1:0]       min_value,
	output logic [SAMPLE_BITS-1:0]       max_value,
	output logic                         partial,
	output logic                         last
);

	logic                        active_q;
	logic [CH_W-1:0]             addr_q;
	logic [CH_W-1:0]             last_ch_q;
	logic [mmd_pkg::PIXEL_W-1:0] pixel_q;
	logic                        partial_q;
	logic                        pending_q;
	logic [CH_W-1:0]             pend_ch_q;
	logic                        pend_last_q;
	logic                        out_valid_q;

	logic [mmd_pkg::CHANNEL_W-1:0] channel_q;
	logic [mmd_pkg::PIXEL_W-1:0]   pixel_out_q;
	logic [SAMPLE_BITS-1:0]        min_q;
	logic [SAMPLE_BITS-1:0]        max_q;
	logic                          partial_out_q;
	logic                          last_q;

	logic move;
	logic issue;

	// Read data moves to the output when the output slot frees up; a new
	// read may only go out once the read register is empty or being emptied.
	assign move  = pending_q && (!out_valid_q || !out_stall);
	assign issue = active_q && (!pending_q || move);

	assign busy    = active_q || pending_q;
	assign rd_en   = issue;
	assign rd_addr = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.start) begin
				active_q <= 1'b1;
			end else if (issue && addr_q == last_ch_q) begin
				active_q <= 1'b0;
			end
			if (issue) begin
				pending_q <= 1'b1;
			end else if (move) begin
				pending_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			addr_q    <= '0;
			last_ch_q <= req_last_ch;
			pixel_q   <= req.pixel;
			partial_q <= req.partial;
		end else if (issue) begin
			addr_q <= addr_q + 1'b1;
		end
		if (issue) begin
			pend_ch_q   <= addr_q;
			pend_last_q <= (addr_q == last_ch_q);
		end
		if (move) begin
			channel_q     <= (mmd_pkg::CHANNEL_W)'(pend_ch_q);
			pixel_out_q   <= pixel_q;
			min_q         <= rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
			max_q         <= rd_data[SAMPLE_BITS-1:0];
			partial_out_q <= partial_q;
			last_q        <= pend_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign channel   = channel_q;
	assign pixel     = pixel_out_q;
	assign min_value = min_q;
	assign max_value = max_q;
	assign partial   = partial_out_q;
	assign last      = last_q;

endmodule

### design/multichannel_minmax_decimator.sv
// Multichannel min/max decimator: scan counters, read-modify-write of the
// per-channel min/max store, and the result sweep on window close or end.
// Depends on mmd_pkg, mmd_mem and mmd_sweep.
// Throughput: one sample per cycle while in_stall is low; a sample that closes a
// window or ends the acquisition stalls input until the sweep has passed on all
// its results, which it reads one entry a cycle while out_stall does not hold it.
// A flush passes stage 1, then the sweep's read register and output register.
// Reset clears counters, configuration and valid flags, not the min/max store.
module multichannel_minmax_decimator #(
	parameter int MAX_CHANNELS = mmd_pkg::MAX_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = mmd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	input  logic                              end_of_acquisition,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mmd_pkg::CHANNEL_W-1:0]     channel,
	output logic [mmd_pkg::PIXEL_W-1:0]       pixel,
	output logic signed [SAMPLE_BITS-1:0]     min_value,
	output logic signed [SAMPLE_BITS-1:0]     max_value,
	output logic                              partial,
	output logic                              last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mmd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [mmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int PW   = mmd_pkg::PIXEL_W;

	// configuration
	logic [mmd_pkg::COUNT_W-1:0] chan_cnt_q;
	logic [PW-1:0]               dec_q;
	logic [PW-1:0]               ppf_q;

	// scan state
	logic [CH_W-1:0] pos_q;
	logic [PW-1:0]   scan_q;
	logic [PW-1:0]   pixel_q;

	// stage 1: read-modify-write
	logic                          valid_s1;
	logic [CH_W-1:0]               ch_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          first_s1;
	mmd_pkg::sweep_req_t           req_s1;
	logic [CH_W-1:0]               last_ch_s1;

	logic                          fwd_q;
	logic signed [SAMPLE_BITS-1:0] fwd_min_q;
	logic signed [SAMPLE_BITS-1:0] fwd_max_q;

	logic                 accept;
	logic [CH_W-1:0]      last_ch;
	logic [CH_W-1:0]      ch;
	logic                 at_end;
	logic [PW:0]          scan_inc;
	logic [PW:0]          pixel_inc;
	logic [PW-1:0]        dec_eff;
	logic [PW-1:0]        ppf_eff;
	logic                 close;
	mmd_pkg::sweep_req_t  req_d;
	logic [CH_W-1:0]      req_last_d;

	logic [2*SAMPLE_BITS-1:0]      rd_data;
	logic signed [SAMPLE_BITS-1:0] old_min;
	logic signed [SAMPLE_BITS-1:0] old_max;
	logic signed [SAMPLE_BITS-1:0] new_min;
	logic signed [SAMPLE_BITS-1:0] new_max;

	logic            sw_busy;
	logic            sw_rd_en;
	logic [CH_W-1:0] sw_rd_addr;
	logic            mem_re;
	logic [CH_W-1:0] mem_raddr;
	mmd_pkg::sweep_req_t sw_req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= mmd_pkg::CHANNEL_COUNT_RST;
			dec_q      <= mmd_pkg::DECIMATION_RST;
			ppf_q      <= mmd_pkg::PIXELS_PER_FRAME_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (mmd_pkg::cfg_reg_t'(cfg_index))
				mmd_pkg::REG_CHANNEL_COUNT:    chan_cnt_q <= cfg_data[mmd_pkg::COUNT_W-1:0];
				mmd_pkg::REG_DECIMATION:       dec_q      <= cfg_data;
				mmd_pkg::REG_PIXELS_PER_FRAME: ppf_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Zero counts act as one; too many channels saturate.
	always_comb begin
		if (chan_cnt_q == '0) begin
			last_ch = '0;
		end else if (32'(chan_cnt_q) > 32'(MAX_CHANNELS)) begin
			last_ch = CH_W'(MAX_CHANNELS - 1);
		end else begin
			last_ch = CH_W'(chan_cnt_q - 7'd1);
		end
	end

	assign dec_eff   = (dec_q == '0) ? PW'(1) : dec_q;
	assign ppf_eff   = (ppf_q == '0) ? PW'(1) : ppf_q;
	assign ch        = (pos_q > last_ch) ? last_ch : pos_q;
	assign at_end    = (ch == last_ch);
	assign scan_inc  = {1'b0, scan_q} + 1'b1;
	assign pixel_inc = {1'b0, pixel_q} + 1'b1;
	assign close     = at_end && (scan_inc >= {1'b0, dec_eff});

	// A full close flushes every channel; a partial flush covers all channels
	// once the window holds a whole scan, otherwise only those seen so far.
	always_comb begin
		req_d.start   = close || end_of_acquisition;
		req_d.partial = !close;
		req_d.pixel   = pixel_q;
		if (close || at_end || scan_q != '0) begin
			req_last_d = last_ch;
		end else begin
			req_last_d = ch;
		end
	end

	assign in_stall = (valid_s1 && req_s1.start) || sw_busy;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			scan_q   <= '0;
			pixel_q  <= '0;
			valid_s1 <= 1'b0;
			req_s1   <= '0;
			fwd_q    <= 1'b0;
		end else begin
			valid_s1 <= accept;
			fwd_q    <= accept && valid_s1 && (ch == ch_s1);
			if (accept) begin
				req_s1 <= req_d;
				if (end_of_acquisition) begin
					pos_q   <= '0;
					scan_q  <= '0;
					pixel_q <= '0;
				end else begin
					pos_q <= at_end ? '0 : ch + 1'b1;
					if (at_end) begin
						scan_q <= close ? '0 : scan_inc[PW-1:0];
					end
					if (close) begin
						pixel_q <= (pixel_inc >= {1'b0, ppf_eff}) ? '0 : pixel_inc[PW-1:0];
					end
				end
			end else begin
				req_s1.start <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1      <= ch;
			sample_s1  <= sample;
			first_s1   <= (scan_q == '0);
			last_ch_s1 <= req_last_d;
		end
		fwd_min_q <= new_min;
		fwd_max_q <= new_max;
	end

	// Take the previous beat's result when it wrote the same channel.
	assign old_min = fwd_q ? fwd_min_q : rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign old_max = fwd_q ? fwd_max_q : rd_data[SAMPLE_BITS-1:0];
	assign new_min = (first_s1 || sample_s1 < old_min) ? sample_s1 : old_min;
	assign new_max = (first_s1 || sample_s1 > old_max) ? sample_s1 : old_max;

	assign mem_re    = accept || sw_rd_en;
	assign mem_raddr = sw_rd_en ? sw_rd_addr : ch;

	mmd_mem #(
		.DEPTH  (MAX_CHANNELS),
		.ADDR_W (CH_W),
		.DATA_W (2*SAMPLE_BITS)
	) u_mem (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (ch_s1),
		.wdata ({new_min, new_max}),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	always_comb begin
		sw_req       = req_s1;
		sw_req.start = valid_s1 && req_s1.start;
	end

	mmd_sweep #(
		.CH_W        (CH_W),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_sweep (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (sw_req),
		.req_last_ch (last_ch_s1),
		.busy        (sw_busy),
		.rd_en       (sw_rd_en),
		.rd_addr     (sw_rd_addr),
		.rd_data     (rd_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.channel     (channel),
		.pixel       (pixel),
		.min_value   (min_value),
		.max_value   (max_value),
		.partial     (partial),
		.last        (last)
	);

endmodule
